/* sv/sie_pkg.sv */
// shared types and constants of the small instruction executor
`timescale 1ns / 1ps

package sie_pkg;

    // host operation codes
    localparam logic [2:0] OP_EXEC   = 3'd0;
    localparam logic [2:0] OP_MEM_WR = 3'd1;
    localparam logic [2:0] OP_MEM_RD = 3'd2;
    localparam logic [2:0] OP_REG_WR = 3'd3;
    localparam logic [2:0] OP_REG_RD = 3'd4;

    // instruction classes, bits 1..0
    localparam logic [1:0] CLS_ALU = 2'd0;
    localparam logic [1:0] CLS_BEQ = 2'd1;
    localparam logic [1:0] CLS_MEM = 2'd2;
    localparam logic [1:0] CLS_LI  = 2'd3;

    // register op functions, bits 3..2
    localparam logic [1:0] FN_ADD = 2'd0;
    localparam logic [1:0] FN_AND = 2'd1;
    localparam logic [1:0] FN_OR  = 2'd2;
    localparam logic [1:0] FN_SHL = 2'd3;

    // memory op functions, bits 3..2
    localparam logic [1:0] MFN_LD = 2'd0;
    localparam logic [1:0] MFN_LB = 2'd1;
    localparam logic [1:0] MFN_SD = 2'd2;
    localparam logic [1:0] MFN_SB = 2'd3;

    localparam logic [15:0] HALT_WORD = 16'hFFFF;
    localparam logic [3:0]  PC_IDX    = 4'd14;
    localparam logic [3:0]  ZERO_IDX  = 4'd0;
    localparam int          REG_COUNT = 16;
    localparam int          BANKS     = 8;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] instr_word;
        logic [9:0]  host_mem_addr;
        logic [7:0]  host_mem_byte;
        logic [3:0]  host_reg_index;
        logic [63:0] host_reg_value;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] next_pc;
        logic        halted;
        logic        fault;
        logic [63:0] read_data;
    } t_out_beat;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
        logic wb;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_sts;

endpackage

/* sv/sie_ctrl.sv */
// controller state machine of the small instruction executor
`timescale 1ns / 1ps

module sie_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sie_pkg::t_cmd o_cmd,
    input  sie_pkg::t_sts i_sts
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WB
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            // a new result beat replaces the one leaving, else the register empties
            if (r_state == S_WB && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clear_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.wb     = (r_state == S_WB) && out_free;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/sie_dp.sv */
// datapath of the small instruction executor: register file, byte banks, alu
`timescale 1ns / 1ps

module sie_dp #(
    parameter int MEM_BYTES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sie_pkg::t_cmd     i_cmd,
    output sie_pkg::t_sts     o_sts,
    input  sie_pkg::t_in_beat i_in,
    output sie_pkg::t_out_beat o_out
);

    localparam int BANK_ROWS = (MEM_BYTES + sie_pkg::BANKS - 1) / sie_pkg::BANKS;
    localparam int ROW_W     = $clog2(BANK_ROWS);

    typedef enum logic [1:0] {
        WB_VAL,
        WB_LD8,
        WB_LD1
    } t_wb_src;

    typedef enum logic [1:0] {
        RS_NONE,
        RS_BYTE,
        RS_REG
    } t_rsel;

    // captured item and register file
    sie_pkg::t_in_beat r_item;
    logic [63:0]       r_rf [sie_pkg::REG_COUNT];
    logic [15:0]       r_rf_vld;
    logic [63:0]       r_rda;
    logic [63:0]       r_rdb;
    logic              r_rda_vld;
    logic              r_rdb_vld;
    logic [3:0]        r_ra_idx;
    logic [3:0]        r_rb_idx;
    logic [63:0]       r_pc;
    logic              r_fault;
    logic [ROW_W-1:0]  r_clr_row;

    // exec to write-back
    logic              r_wb_we;
    logic [3:0]        r_wb_idx;
    logic [63:0]       r_wb_val;
    t_wb_src           r_wb_src;
    logic [63:0]       r_pc_nxt;
    logic              r_halt;
    t_rsel             r_rsel;
    logic              r_mem_ok;
    logic [2:0]        r_lo;
    sie_pkg::t_out_beat r_out;

    // next values of the write-back controls
    logic              n_wb_we;
    logic [3:0]        n_wb_idx;
    logic [63:0]       n_wb_val;
    t_wb_src           n_wb_src;
    t_rsel             n_rsel;

    // banks
    logic              bank_we  [sie_pkg::BANKS];
    logic [ROW_W-1:0]  bank_row [sie_pkg::BANKS];
    logic [7:0]        bank_wd  [sie_pkg::BANKS];
    logic [7:0]        r_bank_q [sie_pkg::BANKS];

    // accept-time read selection
    logic [3:0] ra_idx;
    logic [3:0] rb_idx;

    // exec-time signals
    logic [15:0] w;
    logic [1:0]  cls;
    logic [1:0]  fn;
    logic [3:0]  rd;
    logic        is_exec;
    logic        halt;
    logic        instr;
    logic [63:0] pc_view;
    logic [63:0] pc_inc;
    logic [63:0] opa;
    logic [63:0] opb;
    logic [63:0] alu;
    logic [63:0] addr;
    logic        len8;
    logic        in_range;
    logic [2:0]  lo;
    logic [ROW_W-1:0] base_row;
    logic        st_instr;
    logic        st_host;
    logic        mem_instr;

    // write-back signals
    logic [63:0] ld_val;
    logic [63:0] wb_val;
    logic [63:0] pc_new;
    logic [63:0] rdata;

    always_comb begin
        if (i_in.op == sie_pkg::OP_EXEC) begin
            ra_idx = (i_in.instr_word[1:0] == sie_pkg::CLS_ALU) ?
                     i_in.instr_word[11:8] : i_in.instr_word[15:12];
        end else begin
            ra_idx = i_in.host_reg_index;
        end
        rb_idx = (i_in.instr_word[1:0] == sie_pkg::CLS_ALU) ?
                 i_in.instr_word[7:4] : i_in.instr_word[11:8];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item    <= i_in;
            r_ra_idx  <= ra_idx;
            r_rb_idx  <= rb_idx;
            r_rda     <= r_rf[ra_idx];
            r_rdb     <= r_rf[rb_idx];
            r_rda_vld <= r_rf_vld[ra_idx];
            r_rdb_vld <= r_rf_vld[rb_idx];
        end
    end

    always_comb begin
        w         = r_item.instr_word;
        cls       = w[1:0];
        fn        = w[3:2];
        rd        = w[15:12];
        is_exec   = (r_item.op == sie_pkg::OP_EXEC);
        halt      = is_exec && (w == sie_pkg::HALT_WORD);
        instr     = is_exec && !halt;
        pc_inc    = r_pc + 64'd1;
        pc_view   = is_exec ? pc_inc : r_pc;
        // pc is kept outside the array, register zero is never valid
        opa = (r_ra_idx == sie_pkg::PC_IDX) ? pc_view : (r_rda_vld ? r_rda : '0);
        opb = (r_rb_idx == sie_pkg::PC_IDX) ? pc_view : (r_rdb_vld ? r_rdb : '0);

        case (fn)
            sie_pkg::FN_ADD: alu = opa + opb;
            sie_pkg::FN_AND: alu = opa & opb;
            sie_pkg::FN_OR:  alu = opa | opb;
            sie_pkg::FN_SHL: alu = (opb[63:6] != '0) ? '0 : (opa << opb[5:0]);
            default:         alu = '0;
        endcase

        mem_instr = instr && (cls == sie_pkg::CLS_MEM);
        addr      = is_exec ? opb : {54'd0, r_item.host_mem_addr};
        len8      = mem_instr && (fn == sie_pkg::MFN_LD || fn == sie_pkg::MFN_SD);
        in_range  = (addr < 64'(MEM_BYTES)) &&
                    (!len8 || (addr <= 64'(MEM_BYTES - sie_pkg::BANKS)));
        lo        = addr[2:0];
        base_row  = addr[ROW_W+2:3];
        st_instr  = mem_instr && in_range && (fn == sie_pkg::MFN_SD || fn == sie_pkg::MFN_SB);
        st_host   = (r_item.op == sie_pkg::OP_MEM_WR) && in_range;
    end

    // byte lanes: an unaligned doubleword touches each bank once
    always_comb begin
        for (int b = 0; b < sie_pkg::BANKS; b++) begin
            bank_row[b] = i_cmd.clear ? r_clr_row : base_row + ROW_W'(3'(b) < lo);
            bank_we[b]  = i_cmd.clear ||
                          (i_cmd.exec && ((st_instr && (len8 || 3'(b) == lo)) ||
                                          (st_host && 3'(b) == lo)));
            if (i_cmd.clear) begin
                bank_wd[b] = '0;
            end else if (st_host) begin
                bank_wd[b] = r_item.host_mem_byte;
            end else begin
                bank_wd[b] = 8'(opa >> {3'(b) - lo, 3'b000});
            end
        end
    end

    for (genvar g = 0; g < sie_pkg::BANKS; g++) begin : g_bank
        logic [7:0] mem [BANK_ROWS];

        always_ff @(posedge i_clk) begin
            if (bank_we[g]) begin
                mem[bank_row[g]] <= bank_wd[g];
            end
            if (i_cmd.exec) begin
                r_bank_q[g] <= mem[bank_row[g]];
            end
        end
    end

    // write-back selection for the item in execute
    always_comb begin
        n_wb_src = WB_VAL;
        n_wb_we  = 1'b0;
        n_wb_idx = rd;
        n_wb_val = alu;
        n_rsel   = RS_NONE;
        if (instr) begin
            case (cls)
                sie_pkg::CLS_ALU: begin
                    n_wb_we = 1'b1;
                end
                sie_pkg::CLS_LI: begin
                    n_wb_we  = 1'b1;
                    n_wb_val = {{56{w[11]}}, w[11:4]};
                end
                sie_pkg::CLS_MEM: begin
                    if (fn == sie_pkg::MFN_LD) begin
                        n_wb_we  = in_range;
                        n_wb_src = WB_LD8;
                    end else if (fn == sie_pkg::MFN_LB) begin
                        n_wb_we  = in_range;
                        n_wb_src = WB_LD1;
                    end
                end
                default: begin
                    n_wb_we = 1'b0;
                end
            endcase
        end else if (r_item.op == sie_pkg::OP_REG_WR) begin
            n_wb_we  = 1'b1;
            n_wb_idx = r_item.host_reg_index;
            n_wb_val = r_item.host_reg_value;
        end else if (r_item.op == sie_pkg::OP_MEM_RD) begin
            n_rsel = RS_BYTE;
        end else if (r_item.op == sie_pkg::OP_REG_RD) begin
            n_rsel   = RS_REG;
            n_wb_val = opa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_halt   <= halt;
            r_lo     <= lo;
            r_mem_ok <= in_range;
            r_pc_nxt <= instr ? ((cls == sie_pkg::CLS_BEQ && opa == opb) ?
                                 r_pc + {{58{w[7]}}, w[7:2]} : pc_inc) : r_pc;
            r_wb_src <= n_wb_src;
            r_wb_we  <= n_wb_we;
            r_wb_idx <= n_wb_idx;
            r_wb_val <= n_wb_val;
            r_rsel   <= n_rsel;
        end
    end

    always_comb begin
        for (int k = 0; k < sie_pkg::BANKS; k++) begin
            ld_val[8*k +: 8] = r_bank_q[3'(k) + r_lo];
        end
        case (r_wb_src)
            WB_LD8:  wb_val = ld_val;
            WB_LD1:  wb_val = {56'd0, r_bank_q[r_lo]};
            default: wb_val = r_wb_val;
        endcase
        pc_new = (r_wb_we && r_wb_idx == sie_pkg::PC_IDX) ? wb_val : r_pc_nxt;
        case (r_rsel)
            RS_BYTE: rdata = r_mem_ok ? {56'd0, r_bank_q[r_lo]} : '0;
            RS_REG:  rdata = r_wb_val;
            default: rdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb && r_wb_we && r_wb_idx != sie_pkg::ZERO_IDX &&
            r_wb_idx != sie_pkg::PC_IDX) begin
            r_rf[r_wb_idx] <= wb_val;
        end
        if (i_cmd.wb) begin
            r_out.next_pc   <= pc_new;
            r_out.halted    <= r_halt;
            r_out.fault     <= r_fault;
            r_out.read_data <= rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld  <= '0;
            r_pc      <= '0;
            r_fault   <= 1'b0;
            r_clr_row <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
            end
            if (i_cmd.exec && mem_instr && !in_range) begin
                r_fault <= 1'b1;
            end
            if (i_cmd.wb) begin
                r_pc <= pc_new;
                if (r_wb_we && r_wb_idx != sie_pkg::ZERO_IDX &&
                    r_wb_idx != sie_pkg::PC_IDX) begin
                    r_rf_vld[r_wb_idx] <= 1'b1;
                end
            end
        end
    end

    assign o_sts.clear_last = (r_clr_row == ROW_W'(BANK_ROWS - 1));
    assign o_out = r_out;

endmodule

/* sv/small_isa_instruction_executor_top.sv */
// top level of the small instruction executor
`timescale 1ns / 1ps

// Executes one beat at a time: an instruction word (op 0) or a host access to
// the data store or register file (ops 1 to 4), and returns one result beat per
// input beat with the program counter, halt flag, sticky fault flag and read
// data. Each beat goes through register file read, execute with the
// byte-banked data store access, then write-back into the output register; a
// new beat is taken once write-back has stored its result, and the output
// register holds it while the sink stalls. The data store sits in eight byte
// banks so an unaligned little-endian doubleword reaches every byte in one
// access. After reset the store is cleared one row of eight bytes per cycle,
// with input stalled until every row is done.

module small_isa_instruction_executor_top #(
    parameter int MEM_BYTES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sie_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sie_pkg::t_out_beat o_out
);

    // command and status between controller and datapath
    sie_pkg::t_cmd cmd;
    sie_pkg::t_sts sts;

    sie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // register file, pc, fault flag, data banks and output beat register
    sie_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

/* sv/sie_checker.sv */
// port-level checker of the small instruction executor and its bind
`timescale 1ns / 1ps

module sie_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sie_pkg::t_out_beat o_out
);

    logic r_fault_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_seen <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out.fault) begin
            r_fault_seen <= 1'b1;
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result beat changed under stall");

    // fault never clears once reported
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_fault_seen |-> o_out.fault)
        else $error("fault flag dropped");

    // store clearing keeps input stalled right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during store clear");

    // one beat at a time
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken while busy");

endmodule

bind small_isa_instruction_executor_top sie_checker u_sie_checker (.*);
